// File: rtl/core/ltur_pkg.sv
// Package for the link table: slot geometry, op and status codes, roles,
// and the command/status bundles between controller and datapath.
// No dependencies.
package ltur_pkg;

   localparam int SLOTS = 4;
   localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int HANDLE_W = 16;

   localparam logic [HANDLE_W-1:0] INVALID_HANDLE = 16'hFFFF;
   localparam logic [SLOT_IDX_W-1:0] LAST_SLOT = SLOT_IDX_W'(SLOTS - 1);

   localparam logic [2:0] OP_CONNECT    = 3'd0;
   localparam logic [2:0] OP_DISCONNECT = 3'd1;
   localparam logic [2:0] OP_SET_SEC    = 3'd2;
   localparam logic [2:0] OP_QUERY      = 3'd3;
   localparam logic [2:0] OP_ASSIGN     = 3'd4;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_ARG   = 3'd1;
   localparam logic [2:0] ST_STATE = 3'd2;
   localparam logic [2:0] ST_FULL  = 3'd3;
   localparam logic [2:0] ST_VETO  = 3'd4;

   localparam logic [1:0] ROLE_NONE    = 2'd0;
   localparam logic [1:0] ROLE_PHONE   = 2'd1;
   localparam logic [1:0] ROLE_GLASSES = 2'd2;
   localparam logic [1:0] ROLE_BAD     = 2'd3;

   typedef struct packed {
      logic load;
      logic scan_init;
      logic scan_step;
      logic exec;
      logic respond;
   } ltur_cmd_type;

   typedef struct packed {
      logic scan_last;
   } ltur_stat_type;

endpackage

// File: rtl/core/link_table_with_unique_roles_top.sv
// Link table top level: a transaction is accepted when start is high and busy low.
// After acceptance the controller runs two one-slot-per-cycle scans, one execute and one response;
// the result strobe rsp_valid is registered from the response state. A new transaction is taken only
// from idle, and busy drops in the cycle the result is shown.
// The receiver cannot stall; each result is shown for one cycle.
// Synchronous active-high reset empties the table and clears veto_enabled.
module link_table_with_unique_roles_top
   import ltur_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_op,
   input  logic [HANDLE_W-1:0] req_handle,
   input  logic                req_want_encrypted,
   input  logic                req_want_bonded,
   input  logic                req_want_authorized,
   input  logic [1:0]          req_proposed_role,
   input  logic                req_veto,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data,
   output logic                rsp_valid,
   output logic [2:0]          rsp_status,
   output logic                rsp_found,
   output logic [1:0]          rsp_role_out,
   output logic [2:0]          rsp_sec_bits,
   output logic                rsp_phone_taken,
   output logic                rsp_glasses_taken
);

   ltur_cmd_type  cmd;
   ltur_stat_type stat;

   ltur_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   ltur_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_op              (req_op),
      .req_handle          (req_handle),
      .req_want_encrypted  (req_want_encrypted),
      .req_want_bonded     (req_want_bonded),
      .req_want_authorized (req_want_authorized),
      .req_proposed_role   (req_proposed_role),
      .req_veto            (req_veto),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_status          (rsp_status),
      .rsp_found           (rsp_found),
      .rsp_role_out        (rsp_role_out),
      .rsp_sec_bits        (rsp_sec_bits),
      .rsp_phone_taken     (rsp_phone_taken),
      .rsp_glasses_taken   (rsp_glasses_taken)
   );

endmodule

// File: rtl/core/ltur_ctrl.sv
// Controller for the link table: sequences load, first scan, execute,
// second scan and response. Depends on ltur_pkg.
module ltur_ctrl
   import ltur_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   output logic          rsp_valid,
   output ltur_cmd_type  cmd,
   input  ltur_stat_type stat
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN1 = 3'd1;
   localparam logic [2:0] S_EXEC  = 3'd2;
   localparam logic [2:0] S_SCAN2 = 3'd3;
   localparam logic [2:0] S_RESP  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       accept;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load      = 1'b1;
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN1;
            end
         end
         S_SCAN1: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec      = 1'b1;
            cmd.scan_init = 1'b1;
            state_in      = S_SCAN2;
         end
         S_SCAN2: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == S_RESP);
      end
   end

`ifndef SYNTHESIS
   a_resp_strobe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("response strobe missing after response state");
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("response strobe longer than one cycle");
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_SCAN1 && busy))
      else $error("accepted transaction did not start scanning");
   a_exec_next: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) |=> (state_ff == S_SCAN2))
      else $error("execute not followed by second scan");
`endif

endmodule

// File: rtl/core/ltur_dp.sv
// Datapath for the link table: slot storage, request capture, slot scan
// accumulators, operation execution and response registers. Depends on ltur_pkg.
module ltur_dp
   import ltur_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ltur_cmd_type        cmd,
   output ltur_stat_type       stat,
   input  logic [2:0]          req_op,
   input  logic [HANDLE_W-1:0] req_handle,
   input  logic                req_want_encrypted,
   input  logic                req_want_bonded,
   input  logic                req_want_authorized,
   input  logic [1:0]          req_proposed_role,
   input  logic                req_veto,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data,
   output logic [2:0]          rsp_status,
   output logic                rsp_found,
   output logic [1:0]          rsp_role_out,
   output logic [2:0]          rsp_sec_bits,
   output logic                rsp_phone_taken,
   output logic                rsp_glasses_taken
);

   logic                  slot_active_ff [SLOTS];
   logic [HANDLE_W-1:0]   slot_handle_ff [SLOTS];
   logic [2:0]            slot_sec_ff    [SLOTS];
   logic [1:0]            slot_role_ff   [SLOTS];

   logic                  veto_en_ff;

   logic [2:0]            op_ff;
   logic [HANDLE_W-1:0]   handle_ff;
   logic                  enc_ff;
   logic                  bond_ff;
   logic                  auth_ff;
   logic [1:0]            prop_role_ff;
   logic                  veto_ff;

   logic [SLOT_IDX_W-1:0] idx_ff;
   logic                  match_ff;
   logic [SLOT_IDX_W-1:0] match_idx_ff;
   logic [1:0]            match_role_ff;
   logic [2:0]            match_sec_ff;
   logic                  free_ff;
   logic [SLOT_IDX_W-1:0] free_idx_ff;
   logic                  conflict_ff;
   logic                  phone_ff;
   logic                  glasses_ff;
   logic [2:0]            status_ff;
   logic [2:0]            status_in;

   logic                  cur_active;
   logic                  cur_hit;

   logic                  wr_active_en;
   logic                  wr_active_val;
   logic                  wr_handle_en;
   logic                  wr_sec_en;
   logic [2:0]            wr_sec_val;
   logic                  wr_role_en;
   logic [1:0]            wr_role_val;
   logic [SLOT_IDX_W-1:0] wr_idx;

   assign stat.scan_last = (idx_ff == LAST_SLOT);
   assign cur_active     = slot_active_ff[idx_ff];
   assign cur_hit        = cur_active && (slot_handle_ff[idx_ff] == handle_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         veto_en_ff <= 1'b0;
      end else if (csr_wr_en) begin
         veto_en_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff        <= req_op;
         handle_ff    <= req_handle;
         enc_ff       <= req_want_encrypted;
         bond_ff      <= req_want_bonded;
         auth_ff      <= req_want_authorized;
         prop_role_ff <= req_proposed_role;
         veto_ff      <= req_veto;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         idx_ff      <= '0;
         match_ff    <= 1'b0;
         free_ff     <= 1'b0;
         conflict_ff <= 1'b0;
         phone_ff    <= 1'b0;
         glasses_ff  <= 1'b0;
      end else if (cmd.scan_step) begin
         idx_ff <= stat.scan_last ? '0 : idx_ff + 1'b1;
         if (cur_hit && !match_ff) begin
            match_ff      <= 1'b1;
            match_idx_ff  <= idx_ff;
            match_role_ff <= slot_role_ff[idx_ff];
            match_sec_ff  <= slot_sec_ff[idx_ff];
         end
         if (!cur_active && !free_ff) begin
            free_ff     <= 1'b1;
            free_idx_ff <= idx_ff;
         end
         if (cur_active && !cur_hit && slot_role_ff[idx_ff] == prop_role_ff) begin
            conflict_ff <= 1'b1;
         end
         if (cur_active && slot_role_ff[idx_ff] == ROLE_PHONE) begin
            phone_ff <= 1'b1;
         end
         if (cur_active && slot_role_ff[idx_ff] == ROLE_GLASSES) begin
            glasses_ff <= 1'b1;
         end
      end
   end

   always_comb begin
      status_in     = ST_OK;
      wr_active_en  = 1'b0;
      wr_active_val = 1'b0;
      wr_handle_en  = 1'b0;
      wr_sec_en     = 1'b0;
      wr_sec_val    = 3'd0;
      wr_role_en    = 1'b0;
      wr_role_val   = ROLE_NONE;
      wr_idx        = match_idx_ff;
      case (op_ff)
         OP_CONNECT: begin
            if (handle_ff == INVALID_HANDLE) begin
               status_in = ST_ARG;
            end else if (!match_ff) begin
               if (free_ff) begin
                  wr_idx        = free_idx_ff;
                  wr_active_en  = 1'b1;
                  wr_active_val = 1'b1;
                  wr_handle_en  = 1'b1;
                  wr_sec_en     = 1'b1;
                  wr_role_en    = 1'b1;
               end else begin
                  status_in = ST_FULL;
               end
            end
         end
         OP_DISCONNECT: begin
            if (match_ff) begin
               wr_active_en = 1'b1;
               wr_sec_en    = 1'b1;
               wr_role_en   = 1'b1;
            end
         end
         OP_SET_SEC: begin
            if (auth_ff && !(enc_ff && bond_ff)) begin
               status_in = ST_ARG;
            end else if (!match_ff) begin
               status_in = ST_STATE;
            end else begin
               wr_sec_en  = 1'b1;
               wr_sec_val = {auth_ff, bond_ff, enc_ff};
            end
         end
         OP_QUERY: begin
            status_in = ST_OK;
         end
         OP_ASSIGN: begin
            if (!match_ff) begin
               status_in = ST_STATE;
            end else if (prop_role_ff == ROLE_BAD) begin
               status_in = ST_ARG;
            end else if (match_role_ff == prop_role_ff) begin
               status_in = ST_OK;
            end else if (match_role_ff != ROLE_NONE || prop_role_ff == ROLE_NONE) begin
               status_in = ST_STATE;
            end else if (conflict_ff) begin
               status_in = ST_STATE;
            end else if (veto_en_ff && veto_ff) begin
               status_in = ST_VETO;
            end else begin
               wr_role_en  = 1'b1;
               wr_role_val = prop_role_ff;
            end
         end
         default: begin
            status_in = ST_ARG;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_active_ff[i] <= 1'b0;
         end
      end else if (cmd.exec && wr_active_en) begin
         slot_active_ff[wr_idx] <= wr_active_val;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff <= status_in;
         if (wr_handle_en) begin
            slot_handle_ff[wr_idx] <= handle_ff;
         end
         if (wr_sec_en) begin
            slot_sec_ff[wr_idx] <= wr_sec_val;
         end
         if (wr_role_en) begin
            slot_role_ff[wr_idx] <= wr_role_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_status        <= status_ff;
         rsp_found         <= match_ff;
         rsp_role_out      <= match_ff ? match_role_ff : ROLE_NONE;
         rsp_sec_bits      <= match_ff ? match_sec_ff : 3'd0;
         rsp_phone_taken   <= phone_ff;
         rsp_glasses_taken <= glasses_ff;
      end
   end

endmodule

// File: tb/sv/tb_link_table_with_unique_roles_top.sv
// Self-checking testbench for link_table_with_unique_roles_top: a directed table and
// random transactions are checked against a behavioral model of the link table or pinned views.
// Depends on ltur_pkg and the link_table_with_unique_roles_top RTL.
module tb_link_table_with_unique_roles_top;
   import ltur_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] OP_RSVD5 = 3'd5;
   localparam logic [2:0] OP_RSVD6 = 3'd6;
   localparam logic [2:0] OP_RSVD7 = 3'd7;

   localparam logic [HANDLE_W-1:0] H_A = 16'h0000;
   localparam logic [HANDLE_W-1:0] H_B = 16'hFFFE;
   localparam logic [HANDLE_W-1:0] H_C = 16'h5555;
   localparam logic [HANDLE_W-1:0] H_D = 16'hAAAA;
   localparam logic [HANDLE_W-1:0] H_X = 16'hBEEF;
   localparam logic [HANDLE_W-1:0] H_Y = 16'h1234;

   localparam int RANDOM_PHASES = 5;
   localparam int PHASE_ITEMS   = 90;
   localparam int POOL_SIZE     = 6;
   localparam int CYCLE_LIMIT   = 200000;

   typedef struct packed {
      logic [2:0]          op;
      logic [HANDLE_W-1:0] handle;
      logic                enc;
      logic                bond;
      logic                auth;
      logic [1:0]          role;
      logic                veto;
   } link_req_type;

   typedef struct packed {
      logic [2:0] status;
      logic       found;
      logic [1:0] role;
      logic [2:0] sec;
      logic       phone;
      logic       glasses;
   } link_view_type;

   typedef struct packed {
      logic          is_cfg;
      logic          cfg_val;
      link_req_type  req;
      logic          pinned;
      link_view_type view;
   } dir_row_type;

   localparam link_req_type  NO_REQ   = '0;
   localparam link_view_type UNPINNED = '0;

   localparam dir_row_type DIR_ROWS [27] = '{
      '{1'b0, 1'b0, '{OP_QUERY, H_Y, 1'b0, 1'b0, 1'b0, ROLE_NONE, 1'b0},
        1'b1, '{ST_OK, 1'b0, ROLE_NONE, 3'd0, 1'b0, 1'b0}},
      '{1'b0, 1'b0, '{OP_CONNECT, INVALID_HANDLE, 1'b0, 1'b0, 1'b0, ROLE_NONE, 1'b0},
        1'b1, '{ST_ARG, 1'b0, ROLE_NONE, 3'd0, 1'b0, 1'b0}},
      '{1'b0, 1'b0, '{OP_CONNECT, H_A, 1'b0, 1'b0, 1'b0, ROLE_NONE, 1'b0},
        1'b1, '{ST_OK, 1'b1, ROLE_NONE, 3'd0, 1'b0, 1'b0}},
      '{1'b0, 1'b0, '{OP_CONNECT, H_A, 1'b1, 1'b1, 1'b1, ROLE_GLASSES, 1'b1},
        1'b1, '{ST_OK, 1'b1, ROLE_NONE, 3'd0, 1'b0, 1'b0}},
      '{1'b0, 1'b0, '{OP_SET_SEC, H_A, 1'b0, 1'b0, 1'b1, ROLE_NONE, 1'b0},
        1'b1, '{ST_ARG, 1'b1, ROLE_NONE, 3'd0, 1'b0, 1'b0}},
      '{1'b0, 1'b0, '{OP_SET_SEC, H_A, 1'b1, 1'b1, 1'b1, ROLE_NONE, 1'b0},
        1'b1, '{ST_OK, 1'b1, ROLE_NONE, 3'd7, 1'b0, 1'b0}},
      '{1'b0, 1'b0, '{OP_SET_SEC, H_X, 1'b1, 1'b0, 1'b0, ROLE_NONE, 1'b0},
        1'b1, '{ST_STATE, 1'b0, ROLE_NONE, 3'd0, 1'b0, 1'b0}},
      '{1'b0, 1'b0, '{OP_SET_SEC, H_A, 1'b1, 1'b0, 1'b0, ROLE_NONE, 1'b0},
        1'b0, UNPINNED},
      '{1'b0, 1'b0, '{OP_ASSIGN, H_A, 1'b0, 1'b0, 1'b0, ROLE_BAD, 1'b0},
        1'b0, UNPINNED},
      '{1'b0, 1'b0, '{OP_ASSIGN, H_A, 1'b0, 1'b0, 1'b0, ROLE_NONE, 1'b0},
        1'b0, UNPINNED},
      '{1'b0, 1'b0, '{OP_ASSIGN, H_A, 1'b0, 1'b0, 1'b0, ROLE_PHONE, 1'b1},
        1'b0, UNPINNED},
      '{1'b0, 1'b0, '{OP_CONNECT, H_B, 1'b0, 1'b0, 1'b0, ROLE_NONE, 1'b0},
        1'b0, UNPINNED},
      '{1'b0, 1'b0, '{OP_ASSIGN, H_B, 1'b0, 1'b0, 1'b0, ROLE_PHONE, 1'b0},
        1'b0, UNPINNED},
      '{1'b0, 1'b0, '{OP_ASSIGN, H_A, 1'b0, 1'b0, 1'b0, ROLE_GLASSES, 1'b0},
        1'b0, UNPINNED},
      '{1'b0, 1'b0, '{OP_ASSIGN, H_X, 1'b0, 1'b0, 1'b0, ROLE_PHONE, 1'b0},
        1'b0, UNPINNED},
      '{1'b0, 1'b0, '{OP_CONNECT, H_C, 1'b0, 1'b0, 1'b0, ROLE_NONE, 1'b0},
        1'b0, UNPINNED},
      '{1'b0, 1'b0, '{OP_CONNECT, H_D, 1'b0, 1'b0, 1'b0, ROLE_NONE, 1'b0},
        1'b0, UNPINNED},
      '{1'b0, 1'b0, '{OP_CONNECT, H_Y, 1'b0, 1'b0, 1'b0, ROLE_NONE, 1'b0},
        1'b0, UNPINNED},
      '{1'b0, 1'b0, '{OP_RSVD5, H_C, 1'b0, 1'b0, 1'b0, ROLE_NONE, 1'b0},
        1'b0, UNPINNED},
      '{1'b0, 1'b0, '{OP_DISCONNECT, H_X, 1'b0, 1'b0, 1'b0, ROLE_NONE, 1'b0},
        1'b0, UNPINNED},
      '{1'b0, 1'b0, '{OP_DISCONNECT, H_A, 1'b0, 1'b0, 1'b0, ROLE_NONE, 1'b0},
        1'b0, UNPINNED},
      '{1'b0, 1'b0, '{OP_ASSIGN, H_B, 1'b0, 1'b0, 1'b0, ROLE_PHONE, 1'b1},
        1'b0, UNPINNED},
      '{1'b1, 1'b1, NO_REQ, 1'b0, UNPINNED},
      '{1'b0, 1'b0, '{OP_ASSIGN, H_C, 1'b0, 1'b0, 1'b0, ROLE_GLASSES, 1'b1},
        1'b0, UNPINNED},
      '{1'b0, 1'b0, '{OP_ASSIGN, H_C, 1'b0, 1'b0, 1'b0, ROLE_GLASSES, 1'b0},
        1'b0, UNPINNED},
      '{1'b0, 1'b0, '{OP_RSVD6, H_D, 1'b0, 1'b0, 1'b0, ROLE_NONE, 1'b0},
        1'b0, UNPINNED},
      '{1'b0, 1'b0, '{OP_RSVD7, H_D, 1'b1, 1'b1, 1'b1, ROLE_BAD, 1'b1},
        1'b0, UNPINNED}
   };

   logic                clock;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [2:0]          req_op = '0;
   logic [HANDLE_W-1:0] req_handle = '0;
   logic                req_want_encrypted = 1'b0;
   logic                req_want_bonded = 1'b0;
   logic                req_want_authorized = 1'b0;
   logic [1:0]          req_proposed_role = '0;
   logic                req_veto = 1'b0;
   logic                csr_wr_en = 1'b0;
   logic                csr_wr_data = 1'b0;
   logic                rsp_valid;
   logic [2:0]          rsp_status;
   logic                rsp_found;
   logic [1:0]          rsp_role_out;
   logic [2:0]          rsp_sec_bits;
   logic                rsp_phone_taken;
   logic                rsp_glasses_taken;

   logic          pin_valid = 1'b0;
   link_view_type pin_view = '0;

   link_view_type expected_views [$];
   int unsigned   fails = 0;
   int unsigned   cycles = 0;

   logic                link_up     [SLOTS];
   logic [HANDLE_W-1:0] link_handle [SLOTS];
   logic [2:0]          link_sec    [SLOTS];
   logic [1:0]          link_role   [SLOTS];
   logic                veto_on;

   logic [HANDLE_W-1:0] handle_pool [POOL_SIZE];

   link_table_with_unique_roles_top dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_op              (req_op),
      .req_handle          (req_handle),
      .req_want_encrypted  (req_want_encrypted),
      .req_want_bonded     (req_want_bonded),
      .req_want_authorized (req_want_authorized),
      .req_proposed_role   (req_proposed_role),
      .req_veto            (req_veto),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_found           (rsp_found),
      .rsp_role_out        (rsp_role_out),
      .rsp_sec_bits        (rsp_sec_bits),
      .rsp_phone_taken     (rsp_phone_taken),
      .rsp_glasses_taken   (rsp_glasses_taken)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int find_slot(input logic [HANDLE_W-1:0] h);
      for (int i = 0; i < SLOTS; i++) begin
         if (link_up[i] && link_handle[i] == h) return i;
      end
      return -1;
   endfunction

   function automatic void drop_slot(input int i);
      link_up[i]     = 1'b0;
      link_handle[i] = INVALID_HANDLE;
      link_sec[i]    = '0;
      link_role[i]   = ROLE_NONE;
   endfunction

   function automatic link_view_type apply_link_op(input link_req_type r);
      link_view_type v;
      int            s;
      int            free_slot;
      logic          clash;
      v = '0;
      v.status = ST_OK;
      case (r.op)
         OP_CONNECT: begin
            if (r.handle == INVALID_HANDLE) begin
               v.status = ST_ARG;
            end else if (find_slot(r.handle) < 0) begin
               free_slot = -1;
               for (int i = SLOTS - 1; i >= 0; i--) begin
                  if (!link_up[i]) free_slot = i;
               end
               if (free_slot < 0) begin
                  v.status = ST_FULL;
               end else begin
                  drop_slot(free_slot);
                  link_up[free_slot]     = 1'b1;
                  link_handle[free_slot] = r.handle;
               end
            end
         end
         OP_DISCONNECT: begin
            s = find_slot(r.handle);
            if (s >= 0) drop_slot(s);
         end
         OP_SET_SEC: begin
            if (r.auth && !(r.enc && r.bond)) begin
               v.status = ST_ARG;
            end else begin
               s = find_slot(r.handle);
               if (s < 0) v.status = ST_STATE;
               else link_sec[s] = {r.auth, r.bond, r.enc};
            end
         end
         OP_QUERY: begin
         end
         OP_ASSIGN: begin
            s = find_slot(r.handle);
            clash = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
               if (i != s && link_up[i] && link_role[i] == r.role) clash = 1'b1;
            end
            if (s < 0) v.status = ST_STATE;
            else if (r.role == ROLE_BAD) v.status = ST_ARG;
            else if (link_role[s] == r.role) v.status = ST_OK;
            else if (link_role[s] != ROLE_NONE || r.role == ROLE_NONE) v.status = ST_STATE;
            else if (clash) v.status = ST_STATE;
            else if (veto_on && r.veto) v.status = ST_VETO;
            else link_role[s] = r.role;
         end
         default: v.status = ST_ARG;
      endcase
      s = find_slot(r.handle);
      if (s >= 0) begin
         v.found = 1'b1;
         v.role  = link_role[s];
         v.sec   = link_sec[s];
      end
      for (int i = 0; i < SLOTS; i++) begin
         if (link_up[i] && link_role[i] == ROLE_PHONE) v.phone = 1'b1;
         if (link_up[i] && link_role[i] == ROLE_GLASSES) v.glasses = 1'b1;
      end
      return v;
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fails++;
      end
   endfunction

   function automatic link_req_type random_req();
      link_req_type r;
      int           k;
      k = $urandom_range(0, 99);
      if (k < 25) r.op = OP_CONNECT;
      else if (k < 40) r.op = OP_DISCONNECT;
      else if (k < 60) r.op = OP_SET_SEC;
      else if (k < 70) r.op = OP_QUERY;
      else if (k < 95) r.op = OP_ASSIGN;
      else r.op = 3'($urandom_range(OP_RSVD5, OP_RSVD7));
      k = $urandom_range(0, 99);
      if (k < 85) r.handle = handle_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (k < 95) r.handle = HANDLE_W'($urandom);
      else r.handle = INVALID_HANDLE;
      r.enc  = 1'($urandom);
      r.bond = 1'($urandom);
      r.auth = 1'($urandom);
      r.role = 2'($urandom);
      r.veto = 1'($urandom);
      return r;
   endfunction

   task automatic drive_req(input link_req_type r);
      req_op              <= r.op;
      req_handle          <= r.handle;
      req_want_encrypted  <= r.enc;
      req_want_bonded     <= r.bond;
      req_want_authorized <= r.auth;
      req_proposed_role   <= r.role;
      req_veto            <= r.veto;
   endtask

   task automatic send_op(input link_req_type r, input logic pinned,
                          input link_view_type view);
      @(negedge clock);
      start     <= 1'b1;
      pin_valid <= pinned;
      pin_view  <= view;
      drive_req(r);
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_burst(input int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
         drive_req(random_req());
      end
   endtask

   task automatic write_veto(input logic v);
      @(negedge clock);
      start <= 1'b0;
      while (expected_views.size() != 0) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   always @(posedge clock) begin : monitor
      link_view_type want;
      link_req_type  cur;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) drop_slot(i);
         veto_on = 1'b0;
      end else begin
         if (rsp_valid) begin
            if (expected_views.size() == 0) begin
               $error("result with no transaction outstanding");
               fails++;
            end else begin
               want = expected_views.pop_front();
               check_field("status", 16'(want.status), 16'(rsp_status));
               check_field("found", 16'(want.found), 16'(rsp_found));
               check_field("role_out", 16'(want.role), 16'(rsp_role_out));
               check_field("sec_bits", 16'(want.sec), 16'(rsp_sec_bits));
               check_field("phone_taken", 16'(want.phone), 16'(rsp_phone_taken));
               check_field("glasses_taken", 16'(want.glasses), 16'(rsp_glasses_taken));
            end
         end
         if (csr_wr_en) veto_on = csr_wr_data;
         if (start && !busy) begin
            cur = '{req_op, req_handle, req_want_encrypted, req_want_bonded,
                    req_want_authorized, req_proposed_role, req_veto};
            want = apply_link_op(cur);
            if (pin_valid) want = pin_view;
            expected_views.push_back(want);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin : stimulus
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      for (int n = 0; n < $size(DIR_ROWS); n++) begin
         if (DIR_ROWS[n].is_cfg) write_veto(DIR_ROWS[n].cfg_val);
         else send_op(DIR_ROWS[n].req, DIR_ROWS[n].pinned, DIR_ROWS[n].view);
      end
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         write_veto(ph[0]);
         for (int i = 0; i < POOL_SIZE; i++) handle_pool[i] = HANDLE_W'($urandom);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph < RANDOM_PHASES - 1 && $urandom_range(0, 3) == 0)
               idle_burst($urandom_range(1, 18));
            send_op(random_req(), 1'b0, UNPINNED);
         end
      end
      @(negedge clock);
      start <= 1'b0;
      while (expected_views.size() != 0) @(posedge clock);
      repeat (2 * SLOTS + 3) @(posedge clock);
      if (fails == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
